### hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: pixel format converter shared types and constants
// Format codes, Q16 coefficients and helper functions.
// ----------------------------------------------------------------------------
package pfc_pkg;

    typedef enum logic [2:0] {
        FMT_GRAY   = 3'd0,
        FMT_GRAYA  = 3'd1,
        FMT_RGB    = 3'd2,
        FMT_BGR    = 3'd3,
        FMT_RGBA   = 3'd4,
        FMT_BGRA   = 3'd5,
        FMT_YUV422 = 3'd6,
        FMT_BAD    = 3'd7
    } fmt_t;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_DST = 1'b1;

    localparam int unsigned Q_SHIFT = 16;

    // Q16 coefficients
    localparam logic signed [18:0] K_R_V  = 19'sd91947;
    localparam logic signed [18:0] K_G_U  = 19'sd22544;
    localparam logic signed [18:0] K_G_V  = 19'sd46793;
    localparam logic signed [18:0] K_B_U  = 19'sd115999;
    localparam logic signed [18:0] K_Y_R  = 19'sd19595;
    localparam logic signed [18:0] K_Y_G  = 19'sd38470;
    localparam logic signed [18:0] K_Y_B  = 19'sd7471;
    localparam logic signed [18:0] K_U    = 19'sd37028;
    localparam logic signed [18:0] K_V    = 19'sd46727;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [7:0] lum;
    } pix_t;

    typedef logic [7:0] lanes_t [8];

    // Q16 sum divided by 65536 with truncation toward zero
    function automatic logic signed [15:0] qdiv(input logic signed [31:0] x);
        logic signed [31:0] t;
        t = x + (x[31] ? 32'sd65535 : 32'sd0);
        return t[31:16];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [15:0] x);
        if (x < 0) return 8'd0;
        if (x > 16'sd255) return 8'd255;
        return x[7:0];
    endfunction

    // Divide a 10-bit sum by three: multiply by reciprocal, exact below 768
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [21:0] p;
        p = 22'(s) * 22'd1366;
        return p[19:12];
    endfunction

endpackage

### hw/rtl/pfc_yuv_enc.sv
// ----------------------------------------------------------------------------
// pfc_yuv_enc: RGB pair to YUV422 encoder
// Three register stages: luma, chroma products, averaging and clamp.
// ----------------------------------------------------------------------------
module pfc_yuv_enc
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  pix_t       pix0,
    input  pix_t       pix1,
    output logic [7:0] u_out,
    output logic [7:0] y0_out,
    output logic [7:0] v_out,
    output logic [7:0] y1_out
);

    logic signed [15:0] y_reg [2];
    logic signed [8:0]  br_reg [2];
    logic signed [8:0]  rr_reg [2];
    logic signed [15:0] y2_reg [2];
    logic signed [15:0] us_reg [2];
    logic signed [15:0] vs_reg [2];
    logic [7:0] u_reg, y0_reg, v_reg, y1_reg;
    logic signed [15:0] y_next [2];
    logic signed [15:0] us_next, vs_next;

    always_comb begin
        y_next[0] = qdiv(K_Y_R * $signed({1'b0, pix0.r}) + K_Y_G * $signed({1'b0, pix0.g})
                    + K_Y_B * $signed({1'b0, pix0.b}));
        y_next[1] = qdiv(K_Y_R * $signed({1'b0, pix1.r}) + K_Y_G * $signed({1'b0, pix1.g})
                    + K_Y_B * $signed({1'b0, pix1.b}));
        us_next = us_reg[0] + us_reg[1] + 16'sd1024;
        vs_next = vs_reg[0] + vs_reg[1] + 16'sd1024;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                y_reg[k] <= y_next[k];
            end
            br_reg[0] <= $signed({1'b0, pix0.b}) - 9'(y_next[0]);
            br_reg[1] <= $signed({1'b0, pix1.b}) - 9'(y_next[1]);
            rr_reg[0] <= $signed({1'b0, pix0.r}) - 9'(y_next[0]);
            rr_reg[1] <= $signed({1'b0, pix1.r}) - 9'(y_next[1]);
            for (int k = 0; k < 2; k++) begin
                y2_reg[k] <= y_reg[k];
                us_reg[k] <= qdiv(32'(K_U * br_reg[k]));
                vs_reg[k] <= qdiv(32'(K_V * rr_reg[k]));
            end
            // floor halving
            u_reg  <= clamp8((us_next >>> 1) - 16'sd384);
            v_reg  <= clamp8((vs_next >>> 1) - 16'sd384);
            y0_reg <= clamp8(y2_reg[0]);
            y1_reg <= clamp8(y2_reg[1]);
        end
    end

    assign u_out  = u_reg;
    assign y0_out = y0_reg;
    assign v_out  = v_reg;
    assign y1_out = y1_reg;

endmodule

### hw/rtl/pixel_format_converter_core.sv
// ----------------------------------------------------------------------------
// pixel_format_converter_core: packed pixel pair format converter
// Converts a pixel pair per cycle unless stalled: gray, RGB, BGR, alpha, YUV422.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports
// s_        in         s_valid, s_ready, s_src_byte0..7
// m_        out        m_valid, m_ready, m_dst_byte0..7
// cfg       in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One word per cycle unless stalled, through five register stages (decode, luma,
// chroma products, clamp, select into the output register); a result is presented
// once its source word has passed through all of them.
// All stages advance together on a global enable; m_ready low holds the
// whole pipe, only when the output register is full. Reset clears valid bits.
// ----------------------------------------------------------------------------
module pixel_format_converter_core
    import pfc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_src_byte0,
    input  logic [7:0] s_src_byte1,
    input  logic [7:0] s_src_byte2,
    input  logic [7:0] s_src_byte3,
    input  logic [7:0] s_src_byte4,
    input  logic [7:0] s_src_byte5,
    input  logic [7:0] s_src_byte6,
    input  logic [7:0] s_src_byte7,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_dst_byte0,
    output logic [7:0] m_dst_byte1,
    output logic [7:0] m_dst_byte2,
    output logic [7:0] m_dst_byte3,
    output logic [7:0] m_dst_byte4,
    output logic [7:0] m_dst_byte5,
    output logic [7:0] m_dst_byte6,
    output logic [7:0] m_dst_byte7,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);

    localparam int unsigned DEPTH = 5;

    logic [2:0] src_fmt_reg, dst_fmt_reg;
    logic [DEPTH-1:0] vld_reg;
    logic en;
    lanes_t lane;

    // stage 1: decode registers
    pix_t p0_reg, p1_reg;
    lanes_t raw_reg;
    // delay lines for raw lanes and for decoded pixels that bypass the YUV encoder
    lanes_t raw_d_reg [DEPTH-2];
    pix_t p0_d_reg [3];
    pix_t p1_d_reg [3];
    logic [7:0] res_reg [8];
    logic [7:0] res_next [8];

    logic signed [15:0] yu_r [2], yu_g [2], yu_b [2];
    pix_t p0_next, p1_next;
    logic [7:0] eu, ey0, ev, ey1;

    assign en        = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[DEPTH-1];

    assign lane[0] = s_src_byte0;
    assign lane[1] = s_src_byte1;
    assign lane[2] = s_src_byte2;
    assign lane[3] = s_src_byte3;
    assign lane[4] = s_src_byte4;
    assign lane[5] = s_src_byte5;
    assign lane[6] = s_src_byte6;
    assign lane[7] = s_src_byte7;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= 3'd0;
            dst_fmt_reg <= 3'd0;
            vld_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_SRC) src_fmt_reg <= cfg_data;
                else dst_fmt_reg <= cfg_data;
            end
            if (en) vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // YUV decode for both pixels
    always_comb begin
        logic signed [8:0] u, v;
        logic signed [31:0] ys;
        u = $signed({1'b0, lane[0]}) - 9'sd128;
        v = $signed({1'b0, lane[2]}) - 9'sd128;
        for (int k = 0; k < 2; k++) begin
            ys = 32'(lane[1 + 2 * k]) <<< Q_SHIFT;
            yu_r[k] = qdiv(ys + K_R_V * v);
            yu_g[k] = qdiv(ys - K_G_U * u - K_G_V * v);
            yu_b[k] = qdiv(ys + K_B_U * u);
        end
    end

    function automatic pix_t dec(input logic [2:0] f, input lanes_t l, input int k,
                                 input logic [7:0] yr, input logic [7:0] yg,
                                 input logic [7:0] yb);
        pix_t p;
        p = '0;
        case (f)
            FMT_GRAY, FMT_GRAYA: begin
                p.r = l[k * (f == FMT_GRAYA ? 2 : 1)];
                p.g = p.r; p.b = p.r; p.lum = p.r;
                if (f == FMT_GRAYA) p.a = l[k * 2 + 1];
            end
            FMT_RGB, FMT_RGBA: begin
                p.r = l[k * (f == FMT_RGBA ? 4 : 3)];
                p.g = l[k * (f == FMT_RGBA ? 4 : 3) + 1];
                p.b = l[k * (f == FMT_RGBA ? 4 : 3) + 2];
                if (f == FMT_RGBA) p.a = l[k * 4 + 3];
                p.lum = div3(10'(p.r) + 10'(p.g) + 10'(p.b));
            end
            FMT_BGR, FMT_BGRA: begin
                p.b = l[k * (f == FMT_BGRA ? 4 : 3)];
                p.g = l[k * (f == FMT_BGRA ? 4 : 3) + 1];
                p.r = l[k * (f == FMT_BGRA ? 4 : 3) + 2];
                if (f == FMT_BGRA) p.a = l[k * 4 + 3];
                p.lum = div3(10'(p.r) + 10'(p.g) + 10'(p.b));
            end
            default: begin
                p.r = yr; p.g = yg; p.b = yb; p.lum = l[1 + 2 * k];
            end
        endcase
        return p;
    endfunction

    assign p0_next = dec(src_fmt_reg, lane, 0, clamp8(yu_r[0]), clamp8(yu_g[0]),
                         clamp8(yu_b[0]));
    assign p1_next = dec(src_fmt_reg, lane, 1, clamp8(yu_r[1]), clamp8(yu_g[1]),
                         clamp8(yu_b[1]));

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            raw_reg <= lane;
            raw_d_reg[0] <= raw_reg;
            for (int i = 1; i < DEPTH - 2; i++) raw_d_reg[i] <= raw_d_reg[i-1];
            p0_d_reg[0] <= p0_reg;
            p1_d_reg[0] <= p1_reg;
            for (int i = 1; i < 3; i++) begin
                p0_d_reg[i] <= p0_d_reg[i-1];
                p1_d_reg[i] <= p1_d_reg[i-1];
            end
            for (int i = 0; i < 8; i++) res_reg[i] <= res_next[i];
        end
    end

    pfc_yuv_enc u_enc (
        .aclk   (aclk),
        .en     (en),
        .pix0   (p0_reg),
        .pix1   (p1_reg),
        .u_out  (eu),
        .y0_out (ey0),
        .v_out  (ev),
        .y1_out (ey1)
    );

    // final select, aligned with encoder output
    always_comb begin
        pix_t q0, q1;
        q0 = p0_d_reg[2];
        q1 = p1_d_reg[2];
        for (int i = 0; i < 8; i++) res_next[i] = 8'd0;
        if (src_fmt_reg == FMT_BAD || dst_fmt_reg == FMT_BAD) begin
            // all zero
        end else if (src_fmt_reg == dst_fmt_reg) begin
            for (int i = 0; i < 8; i++) begin
                if ((src_fmt_reg inside {FMT_RGBA, FMT_BGRA})
                    || ((src_fmt_reg inside {FMT_RGB, FMT_BGR}) && i < 6)
                    || ((src_fmt_reg inside {FMT_GRAYA, FMT_YUV422}) && i < 4)
                    || i < 2)
                    res_next[i] = raw_d_reg[DEPTH-3][i];
            end
        end else begin
            case (dst_fmt_reg)
                FMT_GRAY: begin
                    res_next[0] = q0.lum; res_next[1] = q1.lum;
                end
                FMT_GRAYA: begin
                    res_next[0] = q0.lum; res_next[1] = q0.a;
                    res_next[2] = q1.lum; res_next[3] = q1.a;
                end
                FMT_RGB: begin
                    res_next[0] = q0.r; res_next[1] = q0.g; res_next[2] = q0.b;
                    res_next[3] = q1.r; res_next[4] = q1.g; res_next[5] = q1.b;
                end
                FMT_BGR: begin
                    res_next[0] = q0.b; res_next[1] = q0.g; res_next[2] = q0.r;
                    res_next[3] = q1.b; res_next[4] = q1.g; res_next[5] = q1.r;
                end
                FMT_RGBA: begin
                    res_next[0] = q0.r; res_next[1] = q0.g; res_next[2] = q0.b;
                    res_next[3] = q0.a; res_next[4] = q1.r; res_next[5] = q1.g;
                    res_next[6] = q1.b; res_next[7] = q1.a;
                end
                FMT_BGRA: begin
                    res_next[0] = q0.b; res_next[1] = q0.g; res_next[2] = q0.r;
                    res_next[3] = q0.a; res_next[4] = q1.b; res_next[5] = q1.g;
                    res_next[6] = q1.r; res_next[7] = q1.a;
                end
                default: begin
                    res_next[0] = eu; res_next[1] = ey0;
                    res_next[2] = ev; res_next[3] = ey1;
                end
            endcase
        end
    end

    assign m_dst_byte0 = res_reg[0];
    assign m_dst_byte1 = res_reg[1];
    assign m_dst_byte2 = res_reg[2];
    assign m_dst_byte3 = res_reg[3];
    assign m_dst_byte4 = res_reg[4];
    assign m_dst_byte5 = res_reg[5];
    assign m_dst_byte6 = res_reg[6];
    assign m_dst_byte7 = res_reg[7];

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted word lost");

endmodule
